[rtl/bhc_pkg.sv]
// Package for the binary header checker: types, codes, defaults and byte-swap helpers.
// Used by bhc_cfg_regs, bhc_in_stage, bhc_parser and the top level; depends on nothing.

package bhc_pkg;

  // defaults for the top-level parameters
  localparam int unsigned HEAD_LEN_DEF   = 8;
  localparam int unsigned SUFFIX_MAX_DEF = 256;

  // configuration port geometry
  localparam int unsigned CFG_DW  = 64;
  localparam int unsigned PADDR_W = 4;
  localparam logic [PADDR_W-1:0] REG_MAGIC_ADDR = 4'h0;
  localparam logic [PADDR_W-1:0] REG_TAIL_ADDR  = 4'h8;

  // field byte position counter, wide enough for the 64-bit time stamp
  localparam int unsigned IDX_W = 3;

  // required header version
  localparam logic [7:0] VERSION_OK = 8'h01;

  // parser phases
  typedef enum logic [3:0] {
    PH_IDLE,
    PH_HEAD,
    PH_SIZE,
    PH_VER,
    PH_SUFFIX,
    PH_DVER,
    PH_INT,
    PH_LONG,
    PH_TIME,
    PH_TAIL,
    PH_DONE
  } phase_e;

  // verdict codes
  typedef enum logic [1:0] {
    ST_NONE   = 2'd0,
    ST_OK     = 2'd1,
    ST_BROKEN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    EN_EQUAL   = 2'd0,
    EN_OTHER   = 2'd1,
    EN_STRANGE = 2'd2
  } endian_e;

  // one input word as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       stream_end;
  } item_t;

  // one result word
  typedef struct packed {
    logic [1:0]  status;
    logic [1:0]  endian_state;
    logic [31:0] header_size;
    logic [7:0]  version;
    logic [7:0]  data_version;
    logic [7:0]  int_bytes;
    logic [7:0]  long_bytes;
    logic [63:0] time_stamp;
    logic [13:0] suffix_length;
    logic [15:0] bytes_counted;
  } res_t;

  function automatic logic [31:0] swap32(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [63:0] swap64(input logic [63:0] v);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[8*(7-i) +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

endpackage

[rtl/bhc_in_if.sv]
// Input channel of the binary header checker: valid/ready plus one header byte word.
// Depends on nothing.

interface bhc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_req;
  logic       stream_end;

  modport source (output valid, output data_byte, output start_req, output stream_end,
                  input ready);
  modport sink   (input valid, input data_byte, input start_req, input stream_end,
                  output ready);
endinterface

[rtl/bhc_res_if.sv]
// Result channel of the binary header checker: valid/ready plus the verdict fields.
// Depends on nothing.

interface bhc_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [1:0]         endian_state;
  logic [31:0]        header_size;
  logic [7:0]         version;
  logic [7:0]         data_version;
  logic [7:0]         int_bytes;
  logic [7:0]         long_bytes;
  logic signed [63:0] time_stamp;
  logic [13:0]        suffix_length;
  logic [15:0]        bytes_counted;

  modport source (output valid, output status, output endian_state, output header_size,
                  output version, output data_version, output int_bytes,
                  output long_bytes, output time_stamp, output suffix_length,
                  output bytes_counted, input ready);
  modport sink   (input valid, input status, input endian_state, input header_size,
                  input version, input data_version, input int_bytes,
                  input long_bytes, input time_stamp, input suffix_length,
                  input bytes_counted, output ready);
endinterface

[rtl/bhc_cfg_regs.sv]
// APB-style register file holding the expected magic and tail signature.
// Depends on bhc_pkg.

module bhc_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bhc_pkg::PADDR_W-1:0]         paddr,
  input  logic [bhc_pkg::CFG_DW-1:0]          pwdata,
  output logic [bhc_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready,
  output logic [63:0]                         magic_o,
  output logic [31:0]                         tail_sig_o
);

  logic [63:0] magic_q;
  logic [31:0] tail_q;
  logic        wr_en;
  logic        sel_magic;

  assign pready    = 1'b1;
  assign wr_en     = psel && penable && pwrite;
  // anything not at the magic address lands in the tail register
  assign sel_magic = (paddr == bhc_pkg::REG_MAGIC_ADDR);

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= '0;
      tail_q  <= '0;
    end else if (wr_en) begin
      if (sel_magic) begin
        magic_q <= pwdata;
      end else begin
        tail_q <= pwdata[31:0];
      end
    end
  end

  // read back
  always_comb begin
    if (sel_magic) begin
      prdata = magic_q;
    end else begin
      prdata = {32'b0, tail_q};
    end
  end

  assign magic_o    = magic_q;
  assign tail_sig_o = tail_q;

endmodule

[rtl/bhc_in_stage.sv]
// Input register of the binary header checker; takes a new word when empty or when the parser takes the held one.
// Depends on bhc_pkg and bhc_in_if.

module bhc_in_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  bhc_in_if.sink          in_i,
  input  logic            take_i,
  output logic            vld_o,
  output bhc_pkg::item_t  item_o
);

  logic           vld_q;
  bhc_pkg::item_t item_q;
  logic           load;

  assign in_i.ready = !vld_q || take_i;
  assign load       = in_i.valid && in_i.ready;

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (load) begin
      vld_q <= 1'b1;
    end else if (take_i) begin
      vld_q <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.data_byte  <= in_i.data_byte;
      item_q.start_req  <= in_i.start_req;
      item_q.stream_end <= in_i.stream_end;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/bhc_parser.sv]
// Header parser state machine and result register of the binary header checker.
// Depends on bhc_pkg and bhc_res_if.

module bhc_parser #(
  parameter int unsigned HeadLen   = bhc_pkg::HEAD_LEN_DEF,
  parameter int unsigned SuffixMax = bhc_pkg::SUFFIX_MAX_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  bhc_pkg::item_t  item_i,
  output logic            take_o,
  input  logic [63:0]     magic_i,
  input  logic [31:0]     tail_sig_i,
  bhc_res_if.source       res_o
);

  localparam int unsigned IdxW = bhc_pkg::IDX_W;
  localparam int unsigned SfxW = $clog2(SuffixMax + 1);
  localparam logic [IdxW-1:0] HeadLast = IdxW'(HeadLen - 1);
  localparam logic [SfxW-1:0] SfxLimit = SfxW'(SuffixMax);

  // parser state
  bhc_pkg::phase_e phase_q, phase_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     cnt_q, cnt_d;
  logic            mok_q, mok_d;
  logic [31:0]     size_q, size_d;
  logic [7:0]      ver_q, ver_d;
  logic [23:0]     small_q, small_d;
  logic [63:0]     time_q, time_d;
  logic [31:0]     tail_q, tail_d;
  logic [SfxW-1:0] sfx_q, sfx_d;

  // result side
  logic             res_vld_q;
  bhc_pkg::res_t    res_q, res_d;
  logic             out_free;
  logic             emit;
  logic             swap;
  bhc_pkg::status_e status;
  bhc_pkg::endian_e endian;
  logic [7:0]       b;
  logic [31:0]      size_res;
  logic [63:0]      time_res;

  // a held result only blocks a word that would produce another one
  assign out_free = !res_vld_q || res_o.ready;
  assign take_o   = vld_i && (out_free || !emit);
  assign b        = item_i.data_byte;

  // next state and verdict for the word in the input register
  always_comb begin
    phase_d = phase_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    mok_d   = mok_q;
    size_d  = size_q;
    ver_d   = ver_q;
    small_d = small_q;
    time_d  = time_q;
    tail_d  = tail_q;
    sfx_d   = sfx_q;
    emit    = 1'b0;
    swap    = 1'b0;
    status  = bhc_pkg::ST_NONE;
    endian  = bhc_pkg::EN_EQUAL;

    if (vld_i) begin
      // restart drops any header in progress
      if (item_i.start_req) begin
        phase_d = bhc_pkg::PH_HEAD;
        idx_d   = '0;
        cnt_d   = '0;
        mok_d   = 1'b1;
        size_d  = '0;
        ver_d   = '0;
        small_d = '0;
        time_d  = '0;
        tail_d  = '0;
        sfx_d   = '0;
      end

      if (phase_d != bhc_pkg::PH_IDLE && phase_d != bhc_pkg::PH_DONE) begin
        if (item_i.stream_end) begin
          // early end of stream
          emit   = 1'b1;
          status = (phase_d == bhc_pkg::PH_HEAD) ? bhc_pkg::ST_NONE : bhc_pkg::ST_BROKEN;
        end else begin
          if (cnt_d != 16'hFFFF) begin
            cnt_d = cnt_d + 16'd1;
          end
          unique case (phase_d)
            bhc_pkg::PH_HEAD: begin
              if (b != magic_i[{idx_d, 3'b000} +: 8]) begin
                mok_d = 1'b0;
              end
              if (idx_d == HeadLast) begin
                if (b != 8'h00) begin
                  mok_d = 1'b0;
                end
                if (!mok_d) begin
                  emit   = 1'b1;
                  status = bhc_pkg::ST_NONE;
                end else begin
                  phase_d = bhc_pkg::PH_SIZE;
                  idx_d   = '0;
                end
              end else begin
                idx_d = idx_d + IdxW'(1);
              end
            end
            bhc_pkg::PH_SIZE: begin
              size_d[{idx_d[1:0], 3'b000} +: 8] = b;
              if (idx_d[1:0] == 2'd3) begin
                phase_d = bhc_pkg::PH_VER;
                idx_d   = '0;
              end else begin
                idx_d = idx_d + IdxW'(1);
              end
            end
            bhc_pkg::PH_VER: begin
              ver_d = b;
              if (b != bhc_pkg::VERSION_OK) begin
                emit   = 1'b1;
                status = bhc_pkg::ST_BROKEN;
              end else begin
                phase_d = bhc_pkg::PH_SUFFIX;
              end
            end
            bhc_pkg::PH_SUFFIX: begin
              if (b == 8'h00) begin
                phase_d = bhc_pkg::PH_DVER;
              end else begin
                sfx_d = sfx_d + SfxW'(1);
                if (sfx_d >= SfxLimit) begin
                  emit   = 1'b1;
                  status = bhc_pkg::ST_BROKEN;
                end
              end
            end
            bhc_pkg::PH_DVER: begin
              small_d[7:0] = b;
              phase_d      = bhc_pkg::PH_INT;
            end
            bhc_pkg::PH_INT: begin
              small_d[15:8] = b;
              phase_d       = bhc_pkg::PH_LONG;
            end
            bhc_pkg::PH_LONG: begin
              small_d[23:16] = b;
              phase_d        = bhc_pkg::PH_TIME;
              idx_d          = '0;
            end
            bhc_pkg::PH_TIME: begin
              time_d[{idx_d, 3'b000} +: 8] = b;
              if (idx_d == 3'd7) begin
                phase_d = bhc_pkg::PH_TAIL;
                idx_d   = '0;
              end else begin
                idx_d = idx_d + IdxW'(1);
              end
            end
            bhc_pkg::PH_TAIL: begin
              tail_d[{idx_d[1:0], 3'b000} +: 8] = b;
              if (idx_d[1:0] != 2'd3) begin
                idx_d = idx_d + IdxW'(1);
              end else begin
                // tail verdict: tail signature picks the endianness, then size field against the bytes counted
                emit = 1'b1;
                if (tail_d == tail_sig_i) begin
                  endian = bhc_pkg::EN_EQUAL;
                  status = (size_d == {16'b0, cnt_d}) ? bhc_pkg::ST_OK
                                                       : bhc_pkg::ST_BROKEN;
                end else if (bhc_pkg::swap32(tail_d) == tail_sig_i) begin
                  endian = bhc_pkg::EN_OTHER;
                  swap   = 1'b1;
                  status = (bhc_pkg::swap32(size_d) == {16'b0, cnt_d}) ? bhc_pkg::ST_OK
                                                                        : bhc_pkg::ST_BROKEN;
                end else begin
                  endian = bhc_pkg::EN_STRANGE;
                  status = bhc_pkg::ST_BROKEN;
                end
              end
            end
            default: begin
              phase_d = bhc_pkg::PH_DONE;
            end
          endcase
        end
      end
    end

    // byte-swapped view of size and time for the other endianness
    size_res = swap ? bhc_pkg::swap32(size_d) : size_d;
    time_res = swap ? bhc_pkg::swap64(time_d) : time_d;

    if (emit) begin
      phase_d = bhc_pkg::PH_DONE;
    end

    res_d.status        = status;
    res_d.endian_state  = endian;
    res_d.header_size   = size_res;
    res_d.version       = ver_d;
    res_d.data_version  = small_d[7:0];
    res_d.int_bytes     = small_d[15:8];
    res_d.long_bytes    = small_d[23:16];
    res_d.time_stamp    = time_res;
    res_d.suffix_length = 14'(sfx_d);
    res_d.bytes_counted = cnt_d;
  end

  // parser state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= bhc_pkg::PH_IDLE;
      idx_q   <= '0;
      cnt_q   <= '0;
      mok_q   <= 1'b1;
      size_q  <= '0;
      ver_q   <= '0;
      small_q <= '0;
      time_q  <= '0;
      tail_q  <= '0;
      sfx_q   <= '0;
    end else if (take_o) begin
      phase_q <= phase_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      mok_q   <= mok_d;
      size_q  <= size_d;
      ver_q   <= ver_d;
      small_q <= small_d;
      time_q  <= time_d;
      tail_q  <= tail_d;
      sfx_q   <= sfx_d;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (out_free) begin
      res_vld_q <= take_o && emit;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (take_o && emit) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid         = res_vld_q;
  assign res_o.status        = res_q.status;
  assign res_o.endian_state  = res_q.endian_state;
  assign res_o.header_size   = res_q.header_size;
  assign res_o.version       = res_q.version;
  assign res_o.data_version  = res_q.data_version;
  assign res_o.int_bytes     = res_q.int_bytes;
  assign res_o.long_bytes    = res_q.long_bytes;
  assign res_o.time_stamp    = res_q.time_stamp;
  assign res_o.suffix_length = res_q.suffix_length;
  assign res_o.bytes_counted = res_q.bytes_counted;

endmodule

[rtl/binary_header_checker_top.sv]
// Top level of the binary header checker: config registers, input register and parser.
// Depends on bhc_pkg, bhc_in_if, bhc_res_if, bhc_cfg_regs, bhc_in_stage and bhc_parser.

// The checker takes one header byte word per clock and gives at most one verdict word per
// header, through the input register and then the result register. A new byte is accepted
// every cycle as long as the result side drains; a held result stalls intake only when the
// next byte would also produce one. The rate of one byte per clock is set by the parser
// state update, which handles a whole byte in a single cycle. Magic and tail signature are
// written through the APB port at byte addresses 0 and 8; the user must write them only
// while the checker is idle, not enforced by the block; no clearing pass runs after reset.

module binary_header_checker_top #(
  parameter int unsigned HeadLen   = bhc_pkg::HEAD_LEN_DEF,
  parameter int unsigned SuffixMax = bhc_pkg::SUFFIX_MAX_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bhc_pkg::PADDR_W-1:0] paddr,
  input  logic [bhc_pkg::CFG_DW-1:0]  pwdata,
  output logic [bhc_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  bhc_in_if.sink                      in_i,
  bhc_res_if.source                   res_o
);

  logic [63:0]    magic;
  logic [31:0]    tail_sig;
  logic           item_vld;
  logic           take;
  bhc_pkg::item_t item;

  // configuration registers
  bhc_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .magic_o    (magic),
    .tail_sig_o (tail_sig)
  );

  // input register
  bhc_in_stage u_in (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .take_i (take),
    .vld_o  (item_vld),
    .item_o (item)
  );

  // parser and result register
  bhc_parser #(
    .HeadLen   (HeadLen),
    .SuffixMax (SuffixMax)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (item_vld),
    .item_i     (item),
    .take_o     (take),
    .magic_i    (magic),
    .tail_sig_i (tail_sig),
    .res_o      (res_o)
  );

endmodule
